// ----- rtl/cpa_pkg.sv -----
// Shared types, codes and constants of the compacting pool allocator.
package cpa_pkg;

    localparam int HANDLES           = 16;
    localparam int BYTE_POOL_DEPTH   = 4096;
    localparam int INT_POOL_DEPTH    = 256;
    localparam int DOUBLE_POOL_DEPTH = 256;

    localparam int FUNC_W   = 2;
    localparam int POOL_W   = 2;
    localparam int HANDLE_W = 4;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 12;
    localparam int ROOM_W   = 13;
    localparam int NPOOLS   = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC  = 2'd0,
        FN_FREE   = 2'd1,
        FN_ROOM   = 2'd2,
        FN_OFFSET = 2'd3
    } cpa_func_t;

    typedef enum logic [POOL_W-1:0] {
        POOL_BYTE   = 2'd0,
        POOL_INT    = 2'd1,
        POOL_DOUBLE = 2'd2,
        POOL_BAD    = 2'd3
    } cpa_pool_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_LIVE      = 3'd2,
        ST_NOT_LIVE  = 3'd3,
        ST_BAD_POOL  = 3'd4
    } cpa_status_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
    } cpa_cmd_t;

    typedef struct packed {
        logic walk_go;
        logic walk_last;
    } cpa_stat_t;

    function automatic logic [ROOM_W-1:0] pool_depth(input logic [POOL_W-1:0] p);
        logic [ROOM_W-1:0] d;
        case (p)
            POOL_BYTE:   d = ROOM_W'(BYTE_POOL_DEPTH);
            POOL_INT:    d = ROOM_W'(INT_POOL_DEPTH);
            POOL_DOUBLE: d = ROOM_W'(DOUBLE_POOL_DEPTH);
            default:     d = '0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/cpa_ctrl.sv -----
// Controller state machine that sequences lookup, execution and the handle walk.
module cpa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cpa_pkg::cpa_stat_t stat,
    output cpa_pkg::cpa_cmd_t  cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WALK = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.walk_go ? S_WALK : S_IDLE;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/cpa_dp.sv -----
// Datapath with the handle table memory, live bits, pool rooms and result registers.
module cpa_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cpa_pkg::cpa_cmd_t               cmd,
    input  logic [cpa_pkg::FUNC_W-1:0]      func,
    input  logic [cpa_pkg::POOL_W-1:0]      pool,
    input  logic [cpa_pkg::HANDLE_W-1:0]    handle,
    input  logic [cpa_pkg::COUNT_W-1:0]     alloc_count,
    output cpa_pkg::cpa_stat_t              stat,
    output logic                            done,
    output logic [cpa_pkg::STATUS_W-1:0]    status,
    output logic [cpa_pkg::COUNT_W-1:0]     byte_count,
    output logic [cpa_pkg::OFFSET_W-1:0]    offset,
    output logic [cpa_pkg::ROOM_W-1:0]      available,
    output logic [cpa_pkg::ROOM_W-1:0]      move_from,
    output logic [cpa_pkg::OFFSET_W-1:0]    move_to,
    output logic [cpa_pkg::COUNT_W-1:0]     move_count
);

    localparam int RW = cpa_pkg::ROOM_W;
    localparam int CW = cpa_pkg::COUNT_W;
    localparam int HW = cpa_pkg::HANDLE_W;
    localparam int PW = cpa_pkg::POOL_W;

    typedef struct packed {
        logic [PW-1:0] pool;
        logic [RW-1:0] offset;
        logic [CW-1:0] count;
    } entry_t;

    entry_t                      mem [cpa_pkg::HANDLES];
    entry_t                      rdata_reg;
    logic [HW-1:0]               mem_raddr;
    logic [HW-1:0]               mem_waddr;
    entry_t                      mem_wdata;
    logic                        mem_we;

    logic [cpa_pkg::FUNC_W-1:0]  func_reg;
    logic [PW-1:0]               pool_reg;
    logic [HW-1:0]               handle_reg;
    logic [CW-1:0]               count_reg;

    logic [cpa_pkg::HANDLES-1:0] live_reg;
    logic [RW-1:0]               room_reg [cpa_pkg::NPOOLS];
    logic [HW-1:0]               idx_reg;

    logic [PW-1:0]               fr_pool_reg;
    logic [RW-1:0]               fr_off_reg;
    logic [CW-1:0]               fr_cnt_reg;

    logic                        done_reg;
    logic [cpa_pkg::STATUS_W-1:0] status_reg;
    logic [CW-1:0]               bytes_reg;
    logic [cpa_pkg::OFFSET_W-1:0] off_reg;
    logic [RW-1:0]               avail_reg;
    logic [RW-1:0]               mfrom_reg;
    logic [cpa_pkg::OFFSET_W-1:0] mto_reg;
    logic [CW-1:0]               mcount_reg;

    cpa_pkg::cpa_status_t        ex_status;
    logic [CW-1:0]               ex_bytes;
    logic [RW-1:0]               ex_off;
    logic [RW-1:0]               ex_avail;
    logic [RW-1:0]               ex_mfrom;
    logic [RW-1:0]               ex_mcount;
    logic                        ex_alloc;
    logic                        ex_free;
    logic [PW-1:0]               ex_room_pool;
    logic [RW-1:0]               ex_room_val;
    logic                        in_range;
    logic                        hok;
    logic [RW-1:0]               room_sel;
    logic [RW-1:0]               room_ent;
    logic [RW-1:0]               fill;
    logic [RW:0]                 end_sum;
    logic [RW:0]                 room_sum;
    logic                        walk_hit;

    function automatic logic [RW-1:0] room_at(input logic [PW-1:0] p,
                                              input logic [RW-1:0] r0,
                                              input logic [RW-1:0] r1,
                                              input logic [RW-1:0] r2);
        logic [RW-1:0] r;
        case (p)
            cpa_pkg::POOL_BYTE:   r = r0;
            cpa_pkg::POOL_INT:    r = r1;
            cpa_pkg::POOL_DOUBLE: r = r2;
            default:              r = '0;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            pool_reg   <= pool;
            handle_reg <= handle;
            count_reg  <= alloc_count;
        end
    end

    always_comb
    begin
        if (cmd.load)
        begin
            mem_raddr = handle;
        end
        else if (cmd.exec)
        begin
            mem_raddr = '0;
        end
        else
        begin
            mem_raddr = idx_reg + HW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign in_range = (32'(handle_reg) < cpa_pkg::HANDLES);
    assign hok      = in_range && live_reg[handle_reg];
    assign room_sel = room_at(pool_reg, room_reg[0], room_reg[1], room_reg[2]);
    assign room_ent = room_at(rdata_reg.pool, room_reg[0], room_reg[1], room_reg[2]);

    always_comb
    begin
        ex_status    = cpa_pkg::ST_OK;
        ex_bytes     = '0;
        ex_off       = '0;
        ex_avail     = '0;
        ex_mfrom     = '0;
        ex_mcount    = '0;
        ex_alloc     = 1'b0;
        ex_free      = 1'b0;
        ex_room_pool = pool_reg;
        ex_room_val  = room_sel;
        fill         = '0;
        end_sum      = '0;
        room_sum     = '0;
        unique case (cpa_pkg::cpa_func_t'(func_reg)) inside
            cpa_pkg::FN_ALLOC, cpa_pkg::FN_ROOM:
            begin
                fill = cpa_pkg::pool_depth(pool_reg) - room_sel;
                if (pool_reg == cpa_pkg::POOL_BAD)
                begin
                    ex_status = cpa_pkg::ST_BAD_POOL;
                end
                else if (func_reg == cpa_pkg::FN_ROOM)
                begin
                    ex_avail = room_sel;
                end
                else if (!in_range)
                begin
                    ex_status = cpa_pkg::ST_NOT_LIVE;
                    ex_avail  = room_sel;
                end
                else if (live_reg[handle_reg])
                begin
                    ex_status = cpa_pkg::ST_LIVE;
                    ex_avail  = room_sel;
                end
                else if (count_reg > room_sel)
                begin
                    ex_status = cpa_pkg::ST_EXHAUSTED;
                    ex_avail  = room_sel;
                end
                else
                begin
                    ex_alloc    = 1'b1;
                    ex_off      = fill;
                    ex_room_val = room_sel - count_reg;
                    ex_avail    = room_sel - count_reg;
                    ex_bytes    = (pool_reg == cpa_pkg::POOL_BYTE) ? count_reg
                                                                   : {count_reg[CW-4:0], 3'b000};
                end
            end
            cpa_pkg::FN_FREE, cpa_pkg::FN_OFFSET:
            begin
                fill = cpa_pkg::pool_depth(rdata_reg.pool) - room_ent;
                if (!hok)
                begin
                    ex_status = cpa_pkg::ST_NOT_LIVE;
                    ex_avail  = room_sel;
                end
                else if (func_reg == cpa_pkg::FN_OFFSET)
                begin
                    ex_off   = rdata_reg.offset;
                    ex_avail = room_ent;
                end
                else
                begin
                    ex_free      = 1'b1;
                    ex_off       = rdata_reg.offset;
                    end_sum      = {1'b0, rdata_reg.offset} + {1'b0, rdata_reg.count};
                    ex_mfrom     = end_sum[RW-1:0];
                    ex_mcount    = ({1'b0, fill} > end_sum) ? fill - end_sum[RW-1:0] : '0;
                    room_sum     = {1'b0, room_ent} + {1'b0, rdata_reg.count};
                    ex_room_pool = rdata_reg.pool;
                    if (room_sum > {1'b0, cpa_pkg::pool_depth(rdata_reg.pool)})
                    begin
                        ex_room_val = cpa_pkg::pool_depth(rdata_reg.pool);
                    end
                    else
                    begin
                        ex_room_val = room_sum[RW-1:0];
                    end
                    ex_avail = ex_room_val;
                end
            end
            default:
            begin
                ex_status = cpa_pkg::ST_OK;
            end
        endcase
    end

    assign walk_hit = (idx_reg != handle_reg) && live_reg[idx_reg] &&
                      (rdata_reg.pool == fr_pool_reg) && (rdata_reg.offset > fr_off_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = handle_reg;
        mem_wdata = rdata_reg;
        if (cmd.exec && ex_alloc)
        begin
            mem_we         = 1'b1;
            mem_wdata.pool   = pool_reg;
            mem_wdata.offset = fill;
            mem_wdata.count  = count_reg;
        end
        else if (cmd.walk && walk_hit)
        begin
            mem_we           = 1'b1;
            mem_waddr        = idx_reg;
            mem_wdata.offset = rdata_reg.offset - fr_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            idx_reg  <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < cpa_pkg::NPOOLS; i++)
            begin
                room_reg[i] <= cpa_pkg::pool_depth(PW'(i));
            end
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                idx_reg <= '0;
                if (ex_alloc)
                begin
                    live_reg[handle_reg] <= 1'b1;
                end
                if (ex_free)
                begin
                    live_reg[handle_reg] <= 1'b0;
                end
                if (ex_alloc || ex_free)
                begin
                    room_reg[ex_room_pool] <= ex_room_val;
                end
            end
            else if (cmd.walk)
            begin
                idx_reg <= idx_reg + HW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg  <= ex_status;
            bytes_reg   <= ex_bytes;
            off_reg     <= ex_off[cpa_pkg::OFFSET_W-1:0];
            avail_reg   <= ex_avail;
            mfrom_reg   <= ex_mfrom;
            mto_reg     <= ex_free ? ex_off[cpa_pkg::OFFSET_W-1:0] : '0;
            mcount_reg  <= ex_mcount;
            fr_pool_reg <= rdata_reg.pool;
            fr_off_reg  <= rdata_reg.offset;
            fr_cnt_reg  <= rdata_reg.count;
        end
    end

    assign stat.walk_go   = ex_free;
    assign stat.walk_last = (idx_reg == HW'(cpa_pkg::HANDLES - 1));

    assign done       = done_reg;
    assign status     = status_reg;
    assign byte_count = bytes_reg;
    assign offset     = off_reg;
    assign available  = avail_reg;
    assign move_from  = mfrom_reg;
    assign move_to    = mto_reg;
    assign move_count = mcount_reg;

endmodule

// ----- rtl/compacting_pool_allocator_core.sv -----
// Top level of the compacting pool allocator: controller plus datapath.
//
//  Channel   Handshake          Word
//  command   start / busy       func, pool, handle, alloc_count
//  result    done (one cycle)   status, byte_count, offset, available,
//                               move_from, move_to, move_count
//
// A command is taken when start is high and busy is low; done shows its
// result once state_reg enters S_EXEC and done_reg registers cmd.exec. Busy
// stays high in S_EXEC only; a successful free adds the S_WALK walk over
// the handle table memory, one entry per cycle. Reset clears all handles and
// fills every pool's room; the result side never stalls.
module compacting_pool_allocator_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cpa_pkg::FUNC_W-1:0]      func,
    input  logic [cpa_pkg::POOL_W-1:0]      pool,
    input  logic [cpa_pkg::HANDLE_W-1:0]    handle,
    input  logic [cpa_pkg::COUNT_W-1:0]     alloc_count,
    output logic                            done,
    output logic [cpa_pkg::STATUS_W-1:0]    status,
    output logic [cpa_pkg::COUNT_W-1:0]     byte_count,
    output logic [cpa_pkg::OFFSET_W-1:0]    offset,
    output logic [cpa_pkg::ROOM_W-1:0]      available,
    output logic [cpa_pkg::ROOM_W-1:0]      move_from,
    output logic [cpa_pkg::OFFSET_W-1:0]    move_to,
    output logic [cpa_pkg::COUNT_W-1:0]     move_count
);

    cpa_pkg::cpa_cmd_t  cmd;
    cpa_pkg::cpa_stat_t stat;

    cpa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cpa_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .pool        (pool),
        .handle      (handle),
        .alloc_count (alloc_count),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .byte_count  (byte_count),
        .offset      (offset),
        .available   (available),
        .move_from   (move_from),
        .move_to     (move_to),
        .move_count  (move_count)
    );

endmodule

// ----- rtl/cpa_checker.sv -----
// Port-level checker for the compacting pool allocator, bound to the top level.
module cpa_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [cpa_pkg::STATUS_W-1:0]    status,
    input logic [cpa_pkg::COUNT_W-1:0]     byte_count,
    input logic [cpa_pkg::COUNT_W-1:0]     move_count
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted word did not raise busy.");

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("Result word did not follow two cycles after acceptance.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == cpa_pkg::ST_OK) || (status == cpa_pkg::ST_EXHAUSTED) ||
                 (status == cpa_pkg::ST_LIVE) || (status == cpa_pkg::ST_NOT_LIVE) ||
                 (status == cpa_pkg::ST_BAD_POOL))
        else $error("Result word carries an undefined status.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != cpa_pkg::ST_OK) |-> (byte_count == '0) && (move_count == '0))
        else $error("Failed command reported bytes or a move.");

endmodule

bind compacting_pool_allocator_core cpa_checker u_cpa_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .byte_count (byte_count),
    .move_count (move_count)
);

// ----- sim/tb_compacting_pool_allocator_core.sv -----
// Testbench for compacting_pool_allocator_core: directed and random commands with a predictor.
module tb_compacting_pool_allocator_core;

    localparam int FW           = cpa_pkg::FUNC_W;
    localparam int PW           = cpa_pkg::POOL_W;
    localparam int HW           = cpa_pkg::HANDLE_W;
    localparam int CW           = cpa_pkg::COUNT_W;
    localparam int SW           = cpa_pkg::STATUS_W;
    localparam int OW           = cpa_pkg::OFFSET_W;
    localparam int RW           = cpa_pkg::ROOM_W;
    localparam int NH           = cpa_pkg::HANDLES;
    localparam int NP           = cpa_pkg::NPOOLS;
    localparam int NUM_RANDOM   = 450;
    localparam int QUIET_TAIL   = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE [NP] = '{cpa_pkg::BYTE_POOL_DEPTH, cpa_pkg::INT_POOL_DEPTH,
                                      cpa_pkg::DOUBLE_POOL_DEPTH};

    typedef struct packed {
        cpa_pkg::cpa_status_t status;
        logic [CW-1:0]        byte_count;
        logic [OW-1:0]        offset;
        logic [RW-1:0]        available;
        logic [RW-1:0]        move_from;
        logic [OW-1:0]        move_to;
        logic [CW-1:0]        move_count;
    } alloc_word_t;

    class alloc_scoreboard;
        bit                 live [NH];
        cpa_pkg::cpa_pool_t owner [NH];
        int                 base [NH];
        int                 length [NH];
        int                 room [NP];
        alloc_word_t        awaited [$];
        int                 errors;

        function new();
            int i;
            for (i = 0; i < NH; i++)
            begin
                live[i]   = 1'b0;
                owner[i]  = cpa_pkg::POOL_BYTE;
                base[i]   = 0;
                length[i] = 0;
            end
            for (i = 0; i < NP; i++)
            begin
                room[i] = POOL_SIZE[i];
            end
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_command(cpa_pkg::cpa_func_t f, cpa_pkg::cpa_pool_t p,
                                   logic [HW-1:0] h, logic [CW-1:0] cnt);
            alloc_word_t r;
            int          fill;
            int          tail;
            int          q;
            int          i;
            r = '0;
            r.status = cpa_pkg::ST_OK;
            if (f == cpa_pkg::FN_ALLOC || f == cpa_pkg::FN_ROOM)
            begin
                if (p == cpa_pkg::POOL_BAD)
                begin
                    r.status = cpa_pkg::ST_BAD_POOL;
                end
                else if (f == cpa_pkg::FN_ROOM)
                begin
                    r.available = RW'(room[p]);
                end
                else if (live[h])
                begin
                    r.status    = cpa_pkg::ST_LIVE;
                    r.available = RW'(room[p]);
                end
                else if (int'(cnt) > room[p])
                begin
                    r.status    = cpa_pkg::ST_EXHAUSTED;
                    r.available = RW'(room[p]);
                end
                else
                begin
                    live[h]      = 1'b1;
                    owner[h]     = p;
                    base[h]      = POOL_SIZE[p] - room[p];
                    length[h]    = int'(cnt);
                    room[p]      = room[p] - int'(cnt);
                    r.offset     = OW'(base[h]);
                    r.byte_count = CW'((p == cpa_pkg::POOL_BYTE) ? int'(cnt) : 8 * int'(cnt));
                    r.available  = RW'(room[p]);
                end
            end
            else if (!live[h])
            begin
                r.status = cpa_pkg::ST_NOT_LIVE;
                if (p != cpa_pkg::POOL_BAD)
                begin
                    r.available = RW'(room[p]);
                end
            end
            else if (f == cpa_pkg::FN_OFFSET)
            begin
                r.offset    = OW'(base[h]);
                r.available = RW'(room[owner[h]]);
            end
            else
            begin
                q    = int'(owner[h]);
                fill = POOL_SIZE[q] - room[q];
                tail = base[h] + length[h];
                r.offset     = OW'(base[h]);
                r.move_to    = OW'(base[h]);
                r.move_from  = RW'(tail);
                r.move_count = CW'((fill > tail) ? fill - tail : 0);
                for (i = 0; i < NH; i++)
                begin
                    if (i != int'(h) && live[i] && owner[i] == owner[h] && base[i] > base[h])
                    begin
                        base[i] = base[i] - length[h];
                    end
                end
                room[q] = room[q] + length[h];
                if (room[q] > POOL_SIZE[q])
                begin
                    room[q] = POOL_SIZE[q];
                end
                live[h]     = 1'b0;
                r.available = RW'(room[q]);
            end
            awaited.push_back(r);
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(alloc_word_t got);
            alloc_word_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = awaited.pop_front();
            match_field("status", want.status, got.status);
            match_field("byte_count", want.byte_count, got.byte_count);
            match_field("offset", want.offset, got.offset);
            match_field("available", want.available, got.available);
            match_field("move_from", want.move_from, got.move_from);
            match_field("move_to", want.move_to, got.move_to);
            match_field("move_count", want.move_count, got.move_count);
        endfunction
    endclass

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          start       = 1'b0;
    logic [FW-1:0] func        = '0;
    logic [PW-1:0] pool        = '0;
    logic [HW-1:0] handle      = '0;
    logic [CW-1:0] alloc_count = '0;
    logic          busy;
    logic          done;
    logic [SW-1:0] status;
    logic [CW-1:0] byte_count;
    logic [OW-1:0] offset;
    logic [RW-1:0] available;
    logic [RW-1:0] move_from;
    logic [OW-1:0] move_to;
    logic [CW-1:0] move_count;

    alloc_scoreboard sb = new();
    int cycles = 0;

    compacting_pool_allocator_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .pool        (pool),
        .handle      (handle),
        .alloc_count (alloc_count),
        .done        (done),
        .status      (status),
        .byte_count  (byte_count),
        .offset      (offset),
        .available   (available),
        .move_from   (move_from),
        .move_to     (move_to),
        .move_count  (move_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result({status, byte_count, offset, available,
                             move_from, move_to, move_count});
        end
        if (rst_n && start && !busy)
        begin
            sb.note_command(cpa_pkg::cpa_func_t'(func), cpa_pkg::cpa_pool_t'(pool),
                            handle, alloc_count);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_command(cpa_pkg::cpa_func_t f, cpa_pkg::cpa_pool_t p, int h, int cnt);
        start       <= 1'b1;
        func        <= f;
        pool        <= p;
        handle      <= HW'(h);
        alloc_count <= CW'(cnt);
        do @(posedge clk); while (busy);
    endtask

    task automatic pause_sender(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic int pick_handle(bit want_live);
        int h;
        int k;
        h = $urandom_range(0, NH - 1);
        for (k = 0; k < NH; k++)
        begin
            if (sb.live[(h + k) % NH] == want_live)
            begin
                return (h + k) % NH;
            end
        end
        return h;
    endfunction

    task automatic random_command();
        int                 roll;
        int                 cnt;
        cpa_pkg::cpa_pool_t p;
        roll = $urandom_range(0, 99);
        p    = cpa_pkg::cpa_pool_t'($urandom_range(0, 2));
        if (roll < 5)
        begin
            send_command(cpa_pkg::FN_ALLOC, p, pick_handle(1'b0), sb.room[p]);
        end
        else if (roll < 45)
        begin
            cnt = (p == cpa_pkg::POOL_BYTE) ? $urandom_range(0, 1000)
                                            : $urandom_range(0, 100);
            send_command(cpa_pkg::FN_ALLOC, p, pick_handle(1'b0), cnt);
        end
        else if (roll < 72)
        begin
            send_command(cpa_pkg::FN_FREE, cpa_pkg::cpa_pool_t'($urandom_range(0, 3)),
                         pick_handle(1'b1), $urandom_range(0, 8191));
        end
        else if (roll < 82)
        begin
            send_command(cpa_pkg::FN_OFFSET, cpa_pkg::cpa_pool_t'($urandom_range(0, 3)),
                         pick_handle(1'b1), $urandom_range(0, 8191));
        end
        else if (roll < 88)
        begin
            send_command(cpa_pkg::FN_ROOM, cpa_pkg::cpa_pool_t'($urandom_range(0, 3)),
                         $urandom_range(0, NH - 1), $urandom_range(0, 8191));
        end
        else
        begin
            send_command(cpa_pkg::cpa_func_t'($urandom_range(0, 3)),
                         cpa_pkg::cpa_pool_t'($urandom_range(0, 3)),
                         $urandom_range(0, NH - 1), $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        int n;
        bit quiet;
        quiet = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(cpa_pkg::FN_ROOM, cpa_pkg::POOL_BYTE, 0, 0);
        send_command(cpa_pkg::FN_ROOM, cpa_pkg::POOL_INT, 0, 0);
        send_command(cpa_pkg::FN_ROOM, cpa_pkg::POOL_BAD, 0, 0);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_BAD, 0, 5);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_BYTE, 0, 0);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_BYTE, 1, 4096);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_BYTE, 2, 1);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_BYTE, 14, 0);
        send_command(cpa_pkg::FN_OFFSET, cpa_pkg::POOL_BAD, 14, 0);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_INT, 3, 256);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_INT, 4, 0);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_INT, 5, 1);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_DOUBLE, 0, 7);
        send_command(cpa_pkg::FN_FREE, cpa_pkg::POOL_BAD, 15, 0);
        send_command(cpa_pkg::FN_OFFSET, cpa_pkg::POOL_INT, 15, 0);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_DOUBLE, 6, 10);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_DOUBLE, 7, 20);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_DOUBLE, 8, 30);
        send_command(cpa_pkg::FN_FREE, cpa_pkg::POOL_BYTE, 7, 0);
        send_command(cpa_pkg::FN_OFFSET, cpa_pkg::POOL_BYTE, 8, 0);
        send_command(cpa_pkg::FN_FREE, cpa_pkg::POOL_DOUBLE, 8, 0);
        send_command(cpa_pkg::FN_ALLOC, cpa_pkg::POOL_BYTE, 9, 8191);
        send_command(cpa_pkg::FN_FREE, cpa_pkg::POOL_INT, 1, 0);
        send_command(cpa_pkg::FN_OFFSET, cpa_pkg::POOL_INT, 14, 0);
        send_command(cpa_pkg::FN_FREE, cpa_pkg::POOL_BYTE, 3, 0);

        for (n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 40 == 0)
            begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            random_command();
            if (n == NUM_RANDOM / 2)
            begin
                // Hold off the sender until every outstanding word has come back.
                start <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            else if (!quiet && n < NUM_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                pause_sender($urandom_range(1, 15));
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cpa_pkg.sv
rtl/cpa_ctrl.sv
rtl/cpa_dp.sv
rtl/compacting_pool_allocator_core.sv
rtl/cpa_checker.sv
sim/tb_compacting_pool_allocator_core.sv
